// ===== hw/rtl/tremolo_lfo_gain_macros.svh =====
// ----------------------------------------------------------------------------
// tremolo lfo gain assertion macros
// shared property shorthands for the checker
// ----------------------------------------------------------------------------
`ifndef TREMOLO_LFO_GAIN_MACROS_SVH
`define TREMOLO_LFO_GAIN_MACROS_SVH

// same-cycle implication, disabled during reset
`define TLG_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define TLG_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/tlg_pkg.sv =====
// ----------------------------------------------------------------------------
// tlg_pkg
// shared widths, constants, register indexes and types of the tremolo block
// ----------------------------------------------------------------------------
package tlg_pkg;

	// default parameter values
	localparam int TLG_COUNT_BITS  = 24;
	localparam int TLG_SAMPLE_BITS = 16;

	// configuration register widths
	localparam int HALF_W = 24;
	localparam int TSTEP_W = 26;
	localparam int PSTEP_W = 27;
	localparam int MODE_W = 2;

	// configuration port shape
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 27;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIANGLE_STEP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PARABOLA_STEP = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_MODE     = 2'd3;

	// wave selection codes, the unused code falls back to the slewed square
	localparam logic [MODE_W-1:0] MODE_SLEW     = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TRIANGLE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PARABOLA = 2'd2;

	// Q1.24 wave words: 26 bits hold -1.0 .. +1.0, sums need 29
	localparam int WAVE_W = 26;
	localparam int SUM_W  = 29;
	localparam int GAIN_W = 27;
	localparam int FRAC_W = 24;

	localparam logic signed [SUM_W-1:0] ONE_Q24   = 29'sd16777216;
	localparam logic signed [SUM_W-1:0] M_ONE_Q24 = -29'sd16777216;
	localparam logic signed [SUM_W-1:0] SLEW_STEP = 29'sd335544;

	// register reset values
	localparam logic [HALF_W-1:0]  HALF_PERIOD_RST   = 24'd11025;
	localparam logic [TSTEP_W-1:0] TRIANGLE_STEP_RST = 26'd3044;
	localparam logic [PSTEP_W-1:0] PARABOLA_STEP_RST = 27'd6087;
	localparam logic [MODE_W-1:0]  WAVE_MODE_RST     = MODE_PARABOLA;

	// configuration as seen by the oscillator
	typedef struct packed {
		logic [HALF_W-1:0]  half_period;
		logic [TSTEP_W-1:0] triangle_step;
		logic [PSTEP_W-1:0] parabola_step;
		logic [MODE_W-1:0]  wave_mode;
	} tlg_cfg_t;

	// limit a wave sum to -1.0 .. +1.0
	function automatic logic signed [WAVE_W-1:0] clamp_one(logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] r;
		if (v > ONE_Q24) begin
			r = ONE_Q24;
		end else if (v < M_ONE_Q24) begin
			r = M_ONE_Q24;
		end else begin
			r = v;
		end
		return r[WAVE_W-1:0];
	endfunction

endpackage

// ===== hw/rtl/tlg_if.sv =====
// ----------------------------------------------------------------------------
// tlg stream interfaces
// valid/ready channels carrying the sample words in and out of the block
// ----------------------------------------------------------------------------
interface tlg_in_if import tlg_pkg::*; #(
	parameter int SAMPLE_BITS = TLG_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic                          restart;

	modport source (output valid, output sample_in, output restart, input ready);
	modport sink (input valid, input sample_in, input restart, output ready);
endinterface

interface tlg_out_if import tlg_pkg::*; #(
	parameter int SAMPLE_BITS = TLG_SAMPLE_BITS
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

// ===== hw/rtl/tlg_lfo.sv =====
// ----------------------------------------------------------------------------
// tlg_lfo
// oscillator state: phase counter, square sign, slewed square, triangle and
// parabola; advances one step per accepted word and registers the chosen wave
// ----------------------------------------------------------------------------
module tlg_lfo import tlg_pkg::*; #(
	parameter int COUNT_BITS = TLG_COUNT_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic                     restart,
	input  tlg_cfg_t                 cfg,
	output logic signed [WAVE_W-1:0] wave_s1
);

	logic [COUNT_BITS-1:0]    phase_q;
	logic                     neg_q;
	logic signed [WAVE_W-1:0] slew_q;
	logic signed [WAVE_W-1:0] tri_q;
	logic signed [WAVE_W-1:0] par_q;

	logic [COUNT_BITS-1:0]      cur_phase;
	logic                       cur_neg;
	logic signed [SUM_W-1:0]    cur_slew;
	logic signed [SUM_W-1:0]    cur_tri;
	logic signed [SUM_W-1:0]    cur_par;
	logic                       flip;
	logic                       new_neg;
	logic [COUNT_BITS-1:0]      phase_nxt;
	logic signed [SUM_W-1:0]    square;
	logic signed [SUM_W-1:0]    slew_sum;
	logic signed [SUM_W-1:0]    tri_sum;
	logic signed [SUM_W-1:0]    tstep;
	logic signed [WAVE_W-1:0]   slew_nxt;
	logic signed [WAVE_W-1:0]   tri_nxt;
	logic signed [WAVE_W-1:0]   par_nxt;
	logic signed [WAVE_W+PSTEP_W:0] par_prod;
	logic signed [SUM_W-1:0]    par_sum;
	logic signed [WAVE_W-1:0]   wave_sel;

	// restart puts the oscillator back to its start before this word
	always_comb begin
		if (restart) begin
			cur_phase = '0;
			cur_neg   = 1'b0;
			cur_slew  = ONE_Q24;
			cur_tri   = M_ONE_Q24;
			cur_par   = '0;
		end else begin
			cur_phase = phase_q;
			cur_neg   = neg_q;
			cur_slew  = SUM_W'(slew_q);
			cur_tri   = SUM_W'(tri_q);
			cur_par   = SUM_W'(par_q);
		end
	end

	// square flips once the counter has passed the half period
	always_comb begin
		flip      = 33'(cur_phase) > 33'(cfg.half_period);
		new_neg   = cur_neg ^ flip;
		phase_nxt = (flip ? '0 : cur_phase) + COUNT_BITS'(1);
		square    = new_neg ? M_ONE_Q24 : ONE_Q24;
	end

	// slewed square creeps toward the square
	always_comb begin
		if (square > cur_slew) begin
			slew_sum = cur_slew + SLEW_STEP;
		end else if (square < cur_slew) begin
			slew_sum = cur_slew - SLEW_STEP;
		end else begin
			slew_sum = cur_slew;
		end
		slew_nxt = clamp_one(slew_sum);
	end

	// triangle integrates the square
	always_comb begin
		tstep   = SUM_W'({1'b0, cfg.triangle_step});
		tri_sum = new_neg ? (cur_tri - tstep) : (cur_tri + tstep);
		tri_nxt = clamp_one(tri_sum);
	end

	// parabola integrates the new triangle, floor of the Q1.24 product
	always_comb begin
		par_prod = tri_nxt * $signed({1'b0, cfg.parabola_step});
		par_sum  = cur_par + par_prod[FRAC_W+SUM_W-1:FRAC_W];
		par_nxt  = clamp_one(par_sum);
	end

	// wave selection
	always_comb begin
		unique case (cfg.wave_mode)
			MODE_TRIANGLE: wave_sel = tri_nxt;
			MODE_PARABOLA: wave_sel = par_nxt;
			MODE_SLEW:     wave_sel = slew_nxt;
			default:       wave_sel = slew_nxt;
		endcase
	end

	// oscillator state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			neg_q   <= 1'b0;
			slew_q  <= ONE_Q24[WAVE_W-1:0];
			tri_q   <= M_ONE_Q24[WAVE_W-1:0];
			par_q   <= '0;
		end else if (step) begin
			phase_q <= phase_nxt;
			neg_q   <= new_neg;
			slew_q  <= slew_nxt;
			tri_q   <= tri_nxt;
			par_q   <= par_nxt;
		end
	end

	// chosen wave for the gain stage
	always_ff @(posedge clk) begin
		if (step) begin
			wave_s1 <= wave_sel;
		end
	end

endmodule

// ===== hw/rtl/tremolo_lfo_gain.sv =====
// ----------------------------------------------------------------------------
// tremolo_lfo_gain
// tremolo: scales each audio sample by (wave + 1) / 2 of a square-based lfo
// ----------------------------------------------------------------------------
// One sample word is taken every clock cycle unless the output stalls; its
// result leaves when the output side is ready. The first stage runs the
// oscillator update (counter compare, slew and triangle add with clamp, the
// parabola multiply-add with clamp) and registers the chosen wave; the second
// stage multiplies the sample by the gain into the output register. The
// oscillator loop closes in the first stage, so the rate holds at one word per
// cycle. Back-pressure on the output stalls both stages; a word can still be
// taken while a finished result waits if the first stage is empty. The user
// writes configuration through cfg_we/cfg_index/cfg_data only while no word is
// in flight, not enforced by the block; wave_mode 3 acts as the slewed square.
// ----------------------------------------------------------------------------
module tremolo_lfo_gain import tlg_pkg::*; #(
	parameter int COUNT_BITS  = TLG_COUNT_BITS,
	parameter int SAMPLE_BITS = TLG_SAMPLE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	tlg_in_if.sink                in_ch,
	tlg_out_if.source             out_ch
);

	tlg_cfg_t cfg_q;

	logic                          valid_s1;
	logic signed [SAMPLE_BITS-1:0] sample_s1;
	logic signed [WAVE_W-1:0]      wave_s1;
	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] out_sample_q;

	logic                                 accept;
	logic                                 advance;
	logic signed [GAIN_W-1:0]             gain;
	logic signed [SAMPLE_BITS+GAIN_W-1:0] prod;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period   <= HALF_PERIOD_RST;
			cfg_q.triangle_step <= TRIANGLE_STEP_RST;
			cfg_q.parabola_step <= PARABOLA_STEP_RST;
			cfg_q.wave_mode     <= WAVE_MODE_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALF_PERIOD:   cfg_q.half_period   <= cfg_data[HALF_W-1:0];
				REG_TRIANGLE_STEP: cfg_q.triangle_step <= cfg_data[TSTEP_W-1:0];
				REG_PARABOLA_STEP: cfg_q.parabola_step <= cfg_data[PSTEP_W-1:0];
				REG_WAVE_MODE:     cfg_q.wave_mode     <= cfg_data[MODE_W-1:0];
				default:           cfg_q               <= cfg_q;
			endcase
		end
	end

	// pipeline handshake
	always_comb begin
		advance      = valid_s1 && (!out_valid_q || out_ch.ready);
		in_ch.ready  = !valid_s1 || advance;
		accept       = in_ch.valid && in_ch.ready;
		out_ch.valid = out_valid_q;
		out_ch.sample_out = out_sample_q;
	end

	// oscillator and wave selection
	tlg_lfo #(
		.COUNT_BITS(COUNT_BITS)
	) u_lfo (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (accept),
		.restart (in_ch.restart),
		.cfg     (cfg_q),
		.wave_s1 (wave_s1)
	);

	// stage one valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	// stage one sample
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= in_ch.sample_in;
		end
	end

	// gain (wave + 1) in Q2.24, then floor of the product over 2^25
	always_comb begin
		gain = GAIN_W'(wave_s1) + ONE_Q24[GAIN_W-1:0];
		prod = sample_s1 * gain;
	end

	// output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ch.ready) begin
			out_valid_q <= valid_s1;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (advance) begin
			out_sample_q <= prod[SAMPLE_BITS+FRAC_W:FRAC_W+1];
		end
	end

endmodule

// ===== hw/rtl/tlg_checker.sv =====
// ----------------------------------------------------------------------------
// tlg_checker
// port-level checks on the tremolo block, bound to the top level
// ----------------------------------------------------------------------------
`include "tremolo_lfo_gain_macros.svh"

module tlg_checker import tlg_pkg::*; #(
	parameter int SAMPLE_BITS = TLG_SAMPLE_BITS
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic signed [SAMPLE_BITS-1:0] sample_out
);

	// a stalled result word stays offered
	`TLG_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")

	// a stalled result word keeps its value
	`TLG_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(sample_out), "result word changed while stalled")

	// an open output side never blocks the input
	`TLG_ASSERT_NOW(a_in_open, clk, arst_n, !out_valid || out_ready, in_ready, "input blocked with output free")

	// an accepted word reaches the output once the output side is free to take it
	`TLG_ASSERT_NEXT(a_latency, clk, arst_n, (in_valid && in_ready) ##1 (!out_valid || out_ready), out_valid, "accepted word did not arrive at the output")

endmodule

bind tremolo_lfo_gain tlg_checker #(
	.SAMPLE_BITS(SAMPLE_BITS)
) u_tlg_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.sample_out (out_ch.sample_out)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the tremolo lfo gain block: a table of directed
// words, then phases of random words under several register settings, each
// output word compared in order with a cycle-free model of the oscillator
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import tlg_pkg::*;

	localparam int     SB           = TLG_SAMPLE_BITS;
	localparam longint UNIT         = 64'sd16777216;
	localparam longint SLEW_INC     = 64'sd335544;
	localparam int     WATCH_LIMIT  = 2000;
	localparam int     HOLD_CYCLES  = 120;
	localparam int     RAND_PHASES  = 9;
	localparam int     PHASE_WORDS  = 100;
	localparam int     SHOW_LIMIT   = 10;
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef enum logic { ROW_WORD, ROW_REG } row_kind_t;

	typedef struct {
		row_kind_t              kind;
		logic [CFG_IDX_W-1:0]   idx;
		logic [CFG_DATA_W-1:0]  data;
		logic signed [SB-1:0]   smp;
		logic                   rst_lfo;
		bit                     known;
		logic signed [SB-1:0]   want;
	} stim_row_t;

	typedef struct {
		logic signed [SB-1:0] pred;
		bit                   known;
		logic signed [SB-1:0] want;
	} due_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// typed expectation travelling alongside each offered word
	bit                    tag_known;
	logic signed [SB-1:0]  tag_want;

	tlg_in_if  in_if ();
	tlg_out_if out_if ();

	tremolo_lfo_gain uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_if),
		.out_ch    (out_if)
	);

	// oscillator model: registers and wave state
	logic [HALF_W-1:0]         m_half;
	logic [TSTEP_W-1:0]        m_tstep;
	logic [PSTEP_W-1:0]        m_pstep;
	logic [MODE_W-1:0]         m_mode;
	logic [TLG_COUNT_BITS-1:0] pos_cnt;
	bit                        sq_neg;
	longint                    slew_wave;
	longint                    tri_wave;
	longint                    para_wave;

	stim_row_t dir_rows[$];
	due_word_t due_words[$];
	int        bad_words;
	int        idle_cycles;
	int        tx_idle_pct;
	int        rx_idle_pct;
	bit        hold_req;

	function automatic longint clip_unit(longint v);
		if (v > UNIT) begin
			return UNIT;
		end else if (v < -UNIT) begin
			return -UNIT;
		end
		return v;
	endfunction

	function automatic void lfo_restart();
		pos_cnt = '0;
		sq_neg = 1'b0;
		slew_wave = UNIT;
		tri_wave = -UNIT;
		para_wave = 0;
	endfunction

	// one sample through the oscillator and the gain, state advances
	function automatic logic signed [SB-1:0] lfo_gain_predict(logic signed [SB-1:0] smp,
		logic rst_lfo);
		longint sq;
		longint wave;
		longint prod;
		if (rst_lfo) begin
			lfo_restart();
		end
		if (pos_cnt > m_half) begin
			sq_neg = !sq_neg;
			pos_cnt = '0;
		end
		sq = sq_neg ? -UNIT : UNIT;
		if (sq > slew_wave) begin
			slew_wave += SLEW_INC;
		end else if (sq < slew_wave) begin
			slew_wave -= SLEW_INC;
		end
		slew_wave = clip_unit(slew_wave);
		tri_wave = clip_unit(sq_neg ? tri_wave - longint'(m_tstep)
			: tri_wave + longint'(m_tstep));
		para_wave = clip_unit(para_wave + ((tri_wave * longint'(m_pstep)) >>> 24));
		case (m_mode)
			MODE_TRIANGLE: wave = tri_wave;
			MODE_PARABOLA: wave = para_wave;
			default:       wave = slew_wave;
		endcase
		prod = (longint'(smp) * (wave + UNIT)) >>> 25;
		pos_cnt = pos_cnt + 1'b1;
		return prod[SB-1:0];
	endfunction

	function automatic void report_bad(string what, logic signed [SB-1:0] want,
		logic signed [SB-1:0] got);
		bad_words++;
		if (bad_words <= SHOW_LIMIT) begin
			$display("mismatch (%s): expected %0d got %0d", what, want, got);
		end
	endfunction

	function automatic void row_word(logic signed [SB-1:0] smp, logic rst_lfo);
		dir_rows.push_back('{ROW_WORD, REG_HALF_PERIOD, '0, smp, rst_lfo, 1'b0, '0});
	endfunction

	function automatic void row_known(logic signed [SB-1:0] smp, logic rst_lfo,
		logic signed [SB-1:0] want);
		dir_rows.push_back('{ROW_WORD, REG_HALF_PERIOD, '0, smp, rst_lfo, 1'b1, want});
	endfunction

	function automatic void row_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		dir_rows.push_back('{ROW_REG, idx, data, '0, 1'b0, 1'b0, '0});
	endfunction

	// clock
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		out_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_if.ready <= 1'b0;
			end else begin
				out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// scoreboard: output words against due words, input words into the model
	always @(posedge clk) begin
		due_word_t d;
		bit moved;
		moved = 1'b0;
		if (arst_n) begin
			if (out_if.valid && out_if.ready) begin
				moved = 1'b1;
				if (due_words.size() == 0) begin
					bad_words++;
					if (bad_words <= SHOW_LIMIT) begin
						$display("unexpected output word %0d", out_if.sample_out);
					end
				end else begin
					d = due_words.pop_front();
					if (out_if.sample_out !== d.pred) begin
						report_bad("sample_out", d.pred, out_if.sample_out);
					end
					if (d.known && out_if.sample_out !== d.want) begin
						report_bad("sample_out, table value", d.want, out_if.sample_out);
					end
				end
			end
			if (in_if.valid && in_if.ready) begin
				moved = 1'b1;
				d.pred = lfo_gain_predict(in_if.sample_in, in_if.restart);
				d.known = tag_known;
				d.want = tag_want;
				due_words.push_back(d);
			end
			// watchdog on cycles without any word moving
			if (moved) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
				if (idle_cycles >= WATCH_LIMIT) begin
					$display("watchdog: no word moved for %0d cycles", WATCH_LIMIT);
					$display("CHECKS FAILED");
					$finish;
				end
			end
		end
	end

	// offer one word after a random gap, return at its acceptance edge
	task automatic send_word(logic signed [SB-1:0] smp, logic rst_lfo, bit known,
		logic signed [SB-1:0] want);
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_if.valid <= 1'b0;
			@(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.sample_in <= smp;
		in_if.restart <= rst_lfo;
		tag_known <= known;
		tag_want <= want;
		@(posedge clk);
		while (!in_if.ready) @(posedge clk);
	endtask

	// stop offering and let the pipeline drain
	task automatic settle();
		in_if.valid <= 1'b0;
		while (due_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_HALF_PERIOD:   m_half = val[HALF_W-1:0];
			REG_TRIANGLE_STEP: m_tstep = val[TSTEP_W-1:0];
			REG_PARABOLA_STEP: m_pstep = val[PSTEP_W-1:0];
			default:           m_mode = val[MODE_W-1:0];
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// main sequence
	initial begin
		logic [HALF_W-1:0]    hp;
		logic [TSTEP_W-1:0]   ts;
		logic [PSTEP_W-1:0]   ps;
		logic [MODE_W-1:0]    md;
		logic signed [SB-1:0] smp;

		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_HALF_PERIOD;
		cfg_data <= '0;
		in_if.valid <= 1'b0;
		in_if.sample_in <= '0;
		in_if.restart <= 1'b0;
		tag_known <= 1'b0;
		tag_want <= '0;
		bad_words = 0;
		idle_cycles = 0;
		hold_req = 1'b0;
		tx_idle_pct = 16;
		rx_idle_pct = 45;

		// register defaults as after reset
		m_half = 24'd11025;
		m_tstep = 26'd3044;
		m_pstep = 27'd6087;
		m_mode = MODE_PARABOLA;
		lfo_restart();

		// defaults, parabola: a zero sample gives zero
		row_known(16'sd0, 1'b0, 16'sd0);
		row_word(16'sd32767, 1'b0);
		row_word(-16'sd32768, 1'b0);
		row_word(16'sd1, 1'b0);
		row_word(-16'sd1, 1'b0);
		// slewed square sits at plus one long before its first flip
		row_reg(REG_WAVE_MODE, CFG_DATA_W'(MODE_SLEW));
		row_known(-16'sd32768, 1'b1, -16'sd32768);
		row_known(16'sd32767, 1'b0, 16'sd32767);
		row_known(-16'sd1, 1'b0, -16'sd1);
		row_known(16'sd12345, 1'b0, 16'sd12345);
		// unused mode code behaves as the slewed square
		row_reg(REG_WAVE_MODE, CFG_DATA_W'(MODE_UNUSED));
		row_known(-16'sd20000, 1'b1, -16'sd20000);
		row_known(16'sd5, 1'b0, 16'sd5);
		// zero parabola step: wave stays at zero, gain one half
		row_reg(REG_PARABOLA_STEP, '0);
		row_reg(REG_WAVE_MODE, CFG_DATA_W'(MODE_PARABOLA));
		row_known(-16'sd32768, 1'b1, -16'sd16384);
		row_known(16'sd32767, 1'b0, 16'sd16383);
		row_known(-16'sd1, 1'b0, -16'sd1);
		// shortest half period, full triangle step: wave jumps end to end
		row_reg(REG_HALF_PERIOD, '0);
		row_reg(REG_TRIANGLE_STEP, CFG_DATA_W'(33554432));
		row_reg(REG_WAVE_MODE, CFG_DATA_W'(MODE_TRIANGLE));
		row_known(-16'sd32768, 1'b1, -16'sd32768);
		row_known(16'sd32767, 1'b0, 16'sd0);
		row_known(-16'sd1, 1'b0, -16'sd1);
		// largest parabola step
		row_reg(REG_PARABOLA_STEP, CFG_DATA_W'(67108864));
		row_reg(REG_WAVE_MODE, CFG_DATA_W'(MODE_PARABOLA));
		row_word(16'sd32767, 1'b1);
		row_word(-16'sd32768, 1'b0);
		row_word(16'sd1000, 1'b0);
		row_word(-16'sd1000, 1'b0);
		// longest half period, no triangle step: parabola pinned at minus one
		row_reg(REG_HALF_PERIOD, CFG_DATA_W'(24'hFFFFFF));
		row_reg(REG_TRIANGLE_STEP, '0);
		row_known(16'sd32767, 1'b1, 16'sd0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_REG) begin
				settle();
				write_reg(dir_rows[i].idx, dir_rows[i].data);
			end else begin
				send_word(dir_rows[i].smp, dir_rows[i].rst_lfo, dir_rows[i].known,
					dir_rows[i].want);
			end
		end

		// random phases, each under a fresh register setting
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph < 3) begin
				tx_idle_pct = 16;
				rx_idle_pct = 45;
			end else if (ph < 6) begin
				tx_idle_pct = 45;
				rx_idle_pct = 16;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			settle();
			case ($urandom_range(5))
				0:       hp = '0;
				1:       hp = '1;
				2:       hp = HALF_W'($urandom_range(0, 24'hFFFFFF));
				default: hp = HALF_W'($urandom_range(1, 60));
			endcase
			// steps mostly matched to the half period, sometimes arbitrary
			if ($urandom_range(3) == 0) begin
				ts = TSTEP_W'($urandom_range(0, 33554432));
				ps = PSTEP_W'($urandom_range(0, 67108864));
			end else if (hp == 0) begin
				ts = 26'd33554432;
				ps = 27'd67108864;
			end else begin
				ts = TSTEP_W'((33554432 + hp / 2) / hp);
				ps = PSTEP_W'((67108864 + hp / 2) / hp);
			end
			md = MODE_W'($urandom_range(0, 3));
			write_reg(REG_HALF_PERIOD, CFG_DATA_W'(hp));
			write_reg(REG_TRIANGLE_STEP, CFG_DATA_W'(ts));
			write_reg(REG_PARABOLA_STEP, CFG_DATA_W'(ps));
			write_reg(REG_WAVE_MODE, CFG_DATA_W'(md));
			// long output hold-off early on so the input backs up
			if (ph == 0) begin
				hold_req = 1'b1;
			end
			for (int k = 0; k < PHASE_WORDS; k++) begin
				case ($urandom_range(15))
					0:       smp = 16'sh8000;
					1:       smp = 16'sh7FFF;
					2:       smp = '0;
					3:       smp = '1;
					default: smp = SB'($urandom());
				endcase
				send_word(smp, ($urandom_range(49) == 0), 1'b0, '0);
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (bad_words == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tlg_pkg.sv
hw/rtl/tlg_if.sv
hw/rtl/tlg_lfo.sv
hw/rtl/tremolo_lfo_gain.sv
hw/rtl/tlg_checker.sv
tb/tb_top.sv
